/* rtl/cts_pkg.sv */
// cts_pkg: types and constants for the corner turn sequencer.
// Stage and command codes, register indexes, reset values, heading math helpers.
// No dependencies.
package cts_pkg;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_ADVANCE  = 3'd1,
    ST_TURN1    = 3'd2,
    ST_STRAIGHT = 3'd3,
    ST_ADVANCE2 = 3'd4,
    ST_TURN2    = 3'd5,
    ST_STARTUP  = 3'd6
  } stage_t;

  typedef enum logic [2:0] {
    CMD_LINE_FOLLOW  = 3'd0,
    CMD_HEADING_HOLD = 3'd1,
    CMD_TURN_TO      = 3'd2,
    CMD_STOP         = 3'd3,
    CMD_NONE         = 3'd4
  } command_t;

  // configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE_TICKS   = 3'd0;
  localparam logic [2:0] REG_STARTUP_PULSES   = 3'd1;
  localparam logic [2:0] REG_ADVANCE_PULSES   = 3'd2;
  localparam logic [2:0] REG_STRAIGHT_LIMIT   = 3'd3;
  localparam logic [2:0] REG_RETURN_ADVANCE   = 3'd4;
  localparam logic [2:0] REG_TURN_ANGLE       = 3'd5;
  localparam logic [2:0] REG_CONVERGE_BAND    = 3'd6;
  localparam logic [2:0] REG_DRIVE_SPEED      = 3'd7;

  // register reset values
  localparam logic [3:0]  RST_DEBOUNCE_TICKS = 4'd3;
  localparam logic [15:0] RST_STARTUP_PULSES = 16'd400;
  localparam logic [15:0] RST_ADVANCE_PULSES = 16'd300;
  localparam logic [15:0] RST_STRAIGHT_LIMIT = 16'd4600;
  localparam logic [15:0] RST_RETURN_ADVANCE = 16'd400;
  localparam logic [11:0] RST_TURN_ANGLE     = 12'd2160;
  localparam logic [8:0]  RST_CONVERGE_BAND  = 9'd48;
  localparam logic [6:0]  RST_DRIVE_SPEED    = 7'd80;

  localparam logic [3:0] DEBOUNCE_MAX = 4'd15;

  // angles in 1/16 degree
  localparam logic signed [15:0] HALF_TURN    = 16'sd2880;
  localparam logic signed [15:0] FULL_TURN    = 16'sd5760;
  localparam logic signed [15:0] ONE_HALF_TURN = 16'sd8640;   // 1.5 turns
  localparam logic signed [15:0] TWO_TURNS    = 16'sd11520;

  // distance since segment start, signed, beyond limit
  function automatic logic past(input logic [31:0] odo, input logic [31:0] start,
                                input logic [15:0] limit);
    logic [31:0] d;
    d = odo - start;
    return $signed(d) > $signed({16'b0, limit});
  endfunction

  // wrapped heading error magnitude below band
  function automatic logic converged(input logic signed [13:0] target,
                                     input logic signed [12:0] yaw,
                                     input logic [8:0] band);
    logic signed [15:0] d;
    logic signed [15:0] w;
    logic signed [15:0] a;
    d = {{2{target[13]}}, target} - {{3{yaw[12]}}, yaw};
    if (d > ONE_HALF_TURN) begin
      w = d - TWO_TURNS;
    end else if (d > HALF_TURN) begin
      w = d - FULL_TURN;
    end else if (d < -ONE_HALF_TURN) begin
      w = d + TWO_TURNS;
    end else if (d < -HALF_TURN) begin
      w = d + FULL_TURN;
    end else begin
      w = d;
    end
    a = w[15] ? -w : w;
    return a < $signed({7'b0, band});
  endfunction

endpackage

/* rtl/corner_turn_sequencer.sv */
// corner_turn_sequencer: corner detection and diagonal turn sequencing.
// An input transfer is captured in the input register; its result then goes to the result register.
// Throughput: one item per cycle while the output is not stalled; input register feeds one logic stage whose
// state update and result register close in the same cycle.
// Reset (rst, synchronous): stage idle, counters and latched heading/distance
// zero, configuration registers at their defaults, both pipeline registers empty.
module corner_turn_sequencer (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [15:0]        wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic signed [12:0] yaw,
  input  logic signed [31:0] distance_pulses,
  input  logic [7:0]         line_bits,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         command,
  output logic [6:0]         speed,
  output logic signed [13:0] heading,
  output logic               pid_clear,
  output logic               encoder_clear,
  output logic [2:0]         phase,
  output logic [7:0]         corners_done
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [3:0]  debounce_ticks;
  logic [15:0] startup_pulses;
  logic [15:0] advance_pulses;
  logic [15:0] straight_limit_pulses;
  logic [15:0] return_advance_pulses;
  logic [11:0] turn_angle;
  logic [8:0]  converge_band;
  logic [6:0]  drive_speed;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks        <= cts_pkg::RST_DEBOUNCE_TICKS;
      startup_pulses        <= cts_pkg::RST_STARTUP_PULSES;
      advance_pulses        <= cts_pkg::RST_ADVANCE_PULSES;
      straight_limit_pulses <= cts_pkg::RST_STRAIGHT_LIMIT;
      return_advance_pulses <= cts_pkg::RST_RETURN_ADVANCE;
      turn_angle            <= cts_pkg::RST_TURN_ANGLE;
      converge_band         <= cts_pkg::RST_CONVERGE_BAND;
      drive_speed           <= cts_pkg::RST_DRIVE_SPEED;
    end else if (wr_en) begin
      case (wr_index)
        cts_pkg::REG_DEBOUNCE_TICKS: debounce_ticks        <= wr_data[3:0];
        cts_pkg::REG_STARTUP_PULSES: startup_pulses        <= wr_data;
        cts_pkg::REG_ADVANCE_PULSES: advance_pulses        <= wr_data;
        cts_pkg::REG_STRAIGHT_LIMIT: straight_limit_pulses <= wr_data;
        cts_pkg::REG_RETURN_ADVANCE: return_advance_pulses <= wr_data;
        cts_pkg::REG_TURN_ANGLE:     turn_angle            <= wr_data[11:0];
        cts_pkg::REG_CONVERGE_BAND:  converge_band         <= wr_data[8:0];
        cts_pkg::REG_DRIVE_SPEED:    drive_speed           <= wr_data[6:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control
  // The logic stage moves whenever the result register is empty or being
  // taken; the input register refills in the same cycle, so a transfer can
  // happen every clock while the output side keeps up.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic advance;
  logic fire;

  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // input register
  logic               s1_kind;
  logic signed [12:0] s1_yaw;
  logic [31:0]        s1_dist;
  logic [7:0]         s1_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_yaw  <= yaw;
      s1_dist <= distance_pulses;
      s1_line <= line_bits;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  cts_pkg::stage_t    stage, stage_next;
  logic [31:0]        segment_start, segment_start_next;
  logic               turn_positive, turn_positive_next;
  logic [3:0]         debounce_count, debounce_count_next;
  logic signed [12:0] origin_heading, origin_heading_next;
  logic [7:0]         corner_count, corner_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage          <= cts_pkg::ST_IDLE;
      segment_start  <= '0;
      turn_positive  <= 1'b0;
      debounce_count <= '0;
      origin_heading <= '0;
      corner_count   <= '0;
    end else if (fire) begin
      stage          <= stage_next;
      segment_start  <= segment_start_next;
      turn_positive  <= turn_positive_next;
      debounce_count <= debounce_count_next;
      origin_heading <= origin_heading_next;
      corner_count   <= corner_count_next;
    end
  end

  // Sensor groups: low nibble black = left, high nibble black = right,
  // sensors 3 and 4 black = middle on the line.
  logic left_dark;
  logic right_dark;
  logic mid_dark;

  assign left_dark  = (s1_line[3:0] == 4'h0);
  assign right_dark = (s1_line[7:4] == 4'h0);
  assign mid_dark   = (s1_line[4:3] == 2'b00);

  // Turn target around the latched origin heading.
  logic signed [13:0] origin_ext;
  logic signed [13:0] turn_target;

  assign origin_ext  = {origin_heading[12], origin_heading};
  assign turn_target = turn_positive ? origin_ext + $signed({2'b0, turn_angle})
                                     : origin_ext - $signed({2'b0, turn_angle});

  // debounce count after this black tick, saturating
  logic [3:0] debounce_inc;
  assign debounce_inc = (debounce_count != cts_pkg::DEBOUNCE_MAX) ?
                        debounce_count + 4'd1 : debounce_count;

  cts_pkg::command_t  cmd;
  logic [6:0]         spd;
  logic signed [13:0] head;
  logic               pclr;
  logic               eclr;

  always_comb begin
    stage_next          = stage;
    segment_start_next  = segment_start;
    turn_positive_next  = turn_positive;
    debounce_count_next = debounce_count;
    origin_heading_next = origin_heading;
    corner_count_next   = corner_count;
    cmd  = cts_pkg::CMD_NONE;
    spd  = '0;
    head = '0;
    pclr = 1'b0;
    eclr = 1'b0;

    if (s1_kind) begin
      // restart: enter the startup run from the current pose
      stage_next          = cts_pkg::ST_STARTUP;
      debounce_count_next = '0;
      corner_count_next   = '0;
      origin_heading_next = s1_yaw;
      segment_start_next  = s1_dist;
    end else begin
      case (stage)
        cts_pkg::ST_STARTUP: begin
          if (cts_pkg::past(s1_dist, segment_start, startup_pulses)) begin
            eclr       = 1'b1;
            stage_next = cts_pkg::ST_IDLE;
          end else begin
            cmd  = cts_pkg::CMD_HEADING_HOLD;
            spd  = drive_speed;
            head = origin_ext;
          end
        end
        cts_pkg::ST_IDLE: begin
          if (left_dark || right_dark) begin
            debounce_count_next = debounce_inc;
            if (debounce_inc >= debounce_ticks) begin
              // corner accepted; both sides black turns positive
              debounce_count_next = '0;
              turn_positive_next  = left_dark;
              origin_heading_next = s1_yaw;
              segment_start_next  = s1_dist;
              stage_next          = cts_pkg::ST_ADVANCE;
            end
          end else begin
            debounce_count_next = '0;
            cmd = cts_pkg::CMD_LINE_FOLLOW;
          end
        end
        cts_pkg::ST_ADVANCE: begin
          if (cts_pkg::past(s1_dist, segment_start, advance_pulses)) begin
            cmd        = cts_pkg::CMD_STOP;
            pclr       = 1'b1;
            stage_next = cts_pkg::ST_TURN1;
          end else begin
            cmd  = cts_pkg::CMD_HEADING_HOLD;
            spd  = drive_speed;
            head = origin_ext;
          end
        end
        cts_pkg::ST_TURN1: begin
          if (cts_pkg::converged(turn_target, s1_yaw, converge_band)) begin
            segment_start_next = s1_dist;
            stage_next         = cts_pkg::ST_STRAIGHT;
          end else begin
            cmd  = cts_pkg::CMD_TURN_TO;
            head = turn_target;
          end
        end
        cts_pkg::ST_STRAIGHT: begin
          if (mid_dark ||
              cts_pkg::past(s1_dist, segment_start, straight_limit_pulses)) begin
            cmd                = cts_pkg::CMD_STOP;
            segment_start_next = s1_dist;
            stage_next         = cts_pkg::ST_ADVANCE2;
          end else begin
            cmd  = cts_pkg::CMD_HEADING_HOLD;
            spd  = drive_speed;
            head = turn_target;
          end
        end
        cts_pkg::ST_ADVANCE2: begin
          if (cts_pkg::past(s1_dist, segment_start, return_advance_pulses)) begin
            cmd        = cts_pkg::CMD_STOP;
            pclr       = 1'b1;
            stage_next = cts_pkg::ST_TURN2;
          end else begin
            cmd  = cts_pkg::CMD_HEADING_HOLD;
            spd  = drive_speed;
            head = turn_target;
          end
        end
        cts_pkg::ST_TURN2: begin
          if (cts_pkg::converged(origin_ext, s1_yaw, converge_band)) begin
            corner_count_next = corner_count + 8'd1;
            stage_next        = cts_pkg::ST_IDLE;
          end else begin
            cmd  = cts_pkg::CMD_TURN_TO;
            head = origin_ext;
          end
        end
        default: begin
          // unused stage code falls back to idle
          stage_next = cts_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: phase and corner count report the state after the tick
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      command       <= cmd;
      speed         <= spd;
      heading       <= head;
      pid_clear     <= pclr;
      encoder_clear <= eclr;
      phase         <= stage_next;
      corners_done  <= corner_count_next;
    end
  end

endmodule

/* sim/corner_turn_sequencer_tb.sv */
`timescale 1ns / 1ps
// corner_turn_sequencer_tb: self-checking bench for the corner turn sequencer.
// Streams control ticks with random gaps and output stalls, predicts every motor command.
// Depends on cts_pkg (rtl/cts_pkg.sv) and rtl/corner_turn_sequencer.sv.
module corner_turn_sequencer_tb;

  localparam int CLK_HALF          = 2;     // 4 ns period
  localparam int RESET_CYCLES      = 10;
  localparam int NUM_SETTINGS      = 8;
  localparam int TICKS_PER_SETTING = 215;
  localparam int HOLD_OFF_AT       = 100;   // input transfers before the long hold-off
  localparam int HOLD_OFF_CYCLES   = 200;
  localparam int PIPE_MARGIN       = 4;     // slack after the bench sees the block drained
  localparam int DRAIN_CYCLES      = 8;
  localparam int WATCHDOG_LIMIT    = 2000;  // cycles with no transfer at all

  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  localparam int SIDE_LEFT  = 0;
  localparam int SIDE_RIGHT = 1;
  localparam int SIDE_BOTH  = 2;

  typedef struct {
    logic               kind;
    logic signed [12:0] yaw;
    logic [31:0]        odo;
    logic [7:0]         bits;
  } tick_t;

  typedef struct {
    cts_pkg::command_t  cmd;
    logic [6:0]         spd;
    logic signed [13:0] head;
    logic               pclr;
    logic               eclr;
    cts_pkg::stage_t    ph;
    logic [7:0]         corners;
  } motor_cmd_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               wr_en = 1'b0;
  logic [2:0]         wr_index = cts_pkg::REG_DEBOUNCE_TICKS;
  logic [15:0]        wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = KIND_TICK;
  logic signed [12:0] yaw = '0;
  logic signed [31:0] distance_pulses = '0;
  logic [7:0]         line_bits = 8'hFF;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         command;
  logic [6:0]         speed;
  logic signed [13:0] heading;
  logic               pid_clear;
  logic               encoder_clear;
  logic [2:0]         phase;
  logic [7:0]         corners_done;

  corner_turn_sequencer dut (
    .clk             (clk),
    .rst             (rst),
    .wr_en           (wr_en),
    .wr_index        (wr_index),
    .wr_data         (wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .kind            (kind),
    .yaw             (yaw),
    .distance_pulses (distance_pulses),
    .line_bits       (line_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .command         (command),
    .speed           (speed),
    .heading         (heading),
    .pid_clear       (pid_clear),
    .encoder_clear   (encoder_clear),
    .phase           (phase),
    .corners_done    (corners_done)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  tick_t      tick_q[$];        // ticks waiting for the driver
  motor_cmd_t motor_cmd_q[$];   // predicted commands, oldest first
  int         errors = 0;
  int         accepted_in = 0;
  int         queued = 0;
  int         idle_cycles = 0;
  bit         in_fire = 1'b0;   // input transfer at the last rising edge

  // predictor copy of the registers, reset values
  logic [3:0]  cfg_debounce  = cts_pkg::RST_DEBOUNCE_TICKS;
  logic [15:0] cfg_startup   = cts_pkg::RST_STARTUP_PULSES;
  logic [15:0] cfg_advance   = cts_pkg::RST_ADVANCE_PULSES;
  logic [15:0] cfg_limit     = cts_pkg::RST_STRAIGHT_LIMIT;
  logic [15:0] cfg_return    = cts_pkg::RST_RETURN_ADVANCE;
  logic [11:0] cfg_angle     = cts_pkg::RST_TURN_ANGLE;
  logic [8:0]  cfg_band      = cts_pkg::RST_CONVERGE_BAND;
  logic [6:0]  cfg_speed     = cts_pkg::RST_DRIVE_SPEED;

  // predictor copy of the sequencer state
  cts_pkg::stage_t    trk_stage   = cts_pkg::ST_IDLE;
  logic [31:0]        trk_start   = '0;
  logic               trk_left    = 1'b0;
  logic [3:0]         trk_debounce = '0;
  logic signed [12:0] trk_origin  = '0;
  logic [7:0]         trk_corners = '0;

  // stimulus generator position: where the imaginary vehicle is
  int          gen_yaw = 0;
  logic [31:0] gen_dist = '0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // signed 32-bit wrap of distance since segment start, strictly beyond limit
  function automatic logic beyond(input logic [31:0] odo, input logic [15:0] lim);
    logic signed [31:0] span;
    span = odo - trk_start;
    return span > $signed({16'b0, lim});
  endfunction

  // wrapped heading error inside the converge band
  function automatic logic settled(input int goal, input int yaw_now);
    int err;
    err = goal - yaw_now;
    while (err > cts_pkg::HALF_TURN) err -= cts_pkg::FULL_TURN;
    while (err < -cts_pkg::HALF_TURN) err += cts_pkg::FULL_TURN;
    if (err < 0) err = -err;
    return err < int'(cfg_band);
  endfunction

  function automatic int turn_goal();
    return trk_left ? int'(trk_origin) + int'(cfg_angle)
                    : int'(trk_origin) - int'(cfg_angle);
  endfunction

  function automatic motor_cmd_t next_motor_cmd(input tick_t t);
    motor_cmd_t r;
    logic       left_blk;
    logic       right_blk;
    logic       mid_blk;
    int         head;
    left_blk  = t.bits[3:0] == 4'h0;
    right_blk = t.bits[7:4] == 4'h0;
    mid_blk   = t.bits[4:3] == 2'b00;
    r.cmd  = cts_pkg::CMD_NONE;
    r.spd  = '0;
    r.pclr = 1'b0;
    r.eclr = 1'b0;
    head   = 0;
    if (t.kind == KIND_RESTART) begin
      trk_stage    = cts_pkg::ST_STARTUP;
      trk_debounce = '0;
      trk_corners  = '0;
      trk_origin   = t.yaw;
      trk_start    = t.odo;
    end else begin
      case (trk_stage)
        cts_pkg::ST_STARTUP: begin
          if (beyond(t.odo, cfg_startup)) begin
            r.eclr    = 1'b1;
            trk_stage = cts_pkg::ST_IDLE;
          end else begin
            r.cmd = cts_pkg::CMD_HEADING_HOLD;
            r.spd = cfg_speed;
            head  = int'(trk_origin);
          end
        end
        cts_pkg::ST_IDLE: begin
          if (left_blk || right_blk) begin
            if (trk_debounce < cts_pkg::DEBOUNCE_MAX) trk_debounce++;
            if (trk_debounce >= cfg_debounce) begin
              // corner accepted; both sides black turns positive
              trk_debounce = '0;
              trk_left     = left_blk;
              trk_origin   = t.yaw;
              trk_start    = t.odo;
              trk_stage    = cts_pkg::ST_ADVANCE;
            end
          end else begin
            trk_debounce = '0;
            r.cmd        = cts_pkg::CMD_LINE_FOLLOW;
          end
        end
        cts_pkg::ST_ADVANCE: begin
          if (beyond(t.odo, cfg_advance)) begin
            r.cmd     = cts_pkg::CMD_STOP;
            r.pclr    = 1'b1;
            trk_stage = cts_pkg::ST_TURN1;
          end else begin
            r.cmd = cts_pkg::CMD_HEADING_HOLD;
            r.spd = cfg_speed;
            head  = int'(trk_origin);
          end
        end
        cts_pkg::ST_TURN1: begin
          if (settled(turn_goal(), int'(t.yaw))) begin
            trk_start = t.odo;
            trk_stage = cts_pkg::ST_STRAIGHT;
          end else begin
            r.cmd = cts_pkg::CMD_TURN_TO;
            head  = turn_goal();
          end
        end
        cts_pkg::ST_STRAIGHT: begin
          if (mid_blk || beyond(t.odo, cfg_limit)) begin
            r.cmd     = cts_pkg::CMD_STOP;
            trk_start = t.odo;
            trk_stage = cts_pkg::ST_ADVANCE2;
          end else begin
            r.cmd = cts_pkg::CMD_HEADING_HOLD;
            r.spd = cfg_speed;
            head  = turn_goal();
          end
        end
        cts_pkg::ST_ADVANCE2: begin
          if (beyond(t.odo, cfg_return)) begin
            r.cmd     = cts_pkg::CMD_STOP;
            r.pclr    = 1'b1;
            trk_stage = cts_pkg::ST_TURN2;
          end else begin
            r.cmd = cts_pkg::CMD_HEADING_HOLD;
            r.spd = cfg_speed;
            head  = turn_goal();
          end
        end
        cts_pkg::ST_TURN2: begin
          if (settled(int'(trk_origin), int'(t.yaw))) begin
            trk_corners++;
            trk_stage = cts_pkg::ST_IDLE;
          end else begin
            r.cmd = cts_pkg::CMD_TURN_TO;
            head  = int'(trk_origin);
          end
        end
        default: trk_stage = cts_pkg::ST_IDLE;
      endcase
    end
    r.head    = head[13:0];
    r.ph      = trk_stage;
    r.corners = trk_corners;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: output check first (a result never leaves in its input's own cycle), then log the input transfer
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    motor_cmd_t want;
    tick_t      t;
    in_fire = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (motor_cmd_q.size() == 0) begin
          $display("%0t: result transfer with none expected, expected nothing, actual cmd %0d",
                   $time, command);
          errors++;
        end else begin
          want = motor_cmd_q.pop_front();
          compare_field("command", 32'(want.cmd), 32'(command));
          compare_field("speed", 32'(want.spd), 32'(speed));
          compare_field("heading", 32'(want.head), 32'(heading));
          compare_field("pid_clear", 32'(want.pclr), 32'(pid_clear));
          compare_field("encoder_clear", 32'(want.eclr), 32'(encoder_clear));
          compare_field("phase", 32'(want.ph), 32'(phase));
          compare_field("corners_done", 32'(want.corners), 32'(corners_done));
        end
      end
      if (in_valid && !in_stall) begin
        t.kind = kind;
        t.yaw  = yaw;
        t.odo  = distance_pulses;
        t.bits = line_bits;
        motor_cmd_q.push_back(next_motor_cmd(t));
        in_fire = 1'b1;
        accepted_in++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[corner_turn_sequencer] ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Gaps: mostly none, some short, a few long; idle mode flips now and then
  // so there are also long stretches at full rate
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(input bit idling);
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: payload changes only when no transfer is pending
  int send_gap  = 0;
  bit send_idle = 1'b1;

  always @(negedge clk) begin
    tick_t nxt;
    logic  drive_v;
    drive_v = in_valid;
    if (rst) begin
      drive_v = 1'b0;
    end else if (!in_valid || in_fire) begin
      if ($urandom_range(0, 99) == 0) send_idle = !send_idle;
      if (send_gap > 0) begin
        send_gap--;
        drive_v = 1'b0;
      end else if (tick_q.size() > 0) begin
        nxt = tick_q.pop_front();
        kind            <= nxt.kind;
        yaw             <= nxt.yaw;
        distance_pulses <= nxt.odo;
        line_bits       <= nxt.bits;
        drive_v  = 1'b1;
        send_gap = pick_gap(send_idle);
      end else begin
        drive_v = 1'b0;
      end
    end
    in_valid <= drive_v;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up
  int recv_gap  = 0;
  bit recv_idle = 1'b0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    logic stall_n;
    if (rst) begin
      stall_n = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      stall_n = 1'b1;
    end else if (!hold_done && accepted_in >= HOLD_OFF_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      stall_n   = 1'b1;
    end else begin
      if ($urandom_range(0, 99) == 0) recv_idle = !recv_idle;
      if (recv_gap > 0) begin
        recv_gap--;
        stall_n = 1'b1;
      end else begin
        stall_n  = 1'b0;
        recv_gap = pick_gap(recv_idle);
      end
    end
    out_stall <= stall_n;
  end

  // ---------------------------------------------------------------------------
  // Configuration writes (block idle only)
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      cts_pkg::REG_DEBOUNCE_TICKS: cfg_debounce = val[3:0];
      cts_pkg::REG_STARTUP_PULSES: cfg_startup  = val;
      cts_pkg::REG_ADVANCE_PULSES: cfg_advance  = val;
      cts_pkg::REG_STRAIGHT_LIMIT: cfg_limit    = val;
      cts_pkg::REG_RETURN_ADVANCE: cfg_return   = val;
      cts_pkg::REG_TURN_ANGLE:     cfg_angle    = val[11:0];
      cts_pkg::REG_CONVERGE_BAND:  cfg_band     = val[8:0];
      cts_pkg::REG_DRIVE_SPEED:    cfg_speed    = val[6:0];
      default: ;
    endcase
  endtask

  task automatic program_setting(input logic [15:0] deb, input logic [15:0] start_p,
                                 input logic [15:0] adv, input logic [15:0] lim,
                                 input logic [15:0] ret, input logic [15:0] ang,
                                 input logic [15:0] band, input logic [15:0] spd);
    write_reg(cts_pkg::REG_DEBOUNCE_TICKS, deb);
    write_reg(cts_pkg::REG_STARTUP_PULSES, start_p);
    write_reg(cts_pkg::REG_ADVANCE_PULSES, adv);
    write_reg(cts_pkg::REG_STRAIGHT_LIMIT, lim);
    write_reg(cts_pkg::REG_RETURN_ADVANCE, ret);
    write_reg(cts_pkg::REG_TURN_ANGLE, ang);
    write_reg(cts_pkg::REG_CONVERGE_BAND, band);
    write_reg(cts_pkg::REG_DRIVE_SPEED, spd);
  endtask

  // everything sent, accepted and answered, then a margin of slack
  task automatic wait_idle();
    do @(posedge clk); while (tick_q.size() != 0 || in_valid || motor_cmd_q.size() != 0);
    repeat (PIPE_MARGIN) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic k, input int y, input logic [31:0] d,
                           input logic [7:0] b);
    tick_t t;
    t.kind = k;
    t.yaw  = y[12:0];
    t.odo  = d;
    t.bits = b;
    tick_q.push_back(t);
    queued++;
  endtask

  function automatic int wrap_yaw(input int a);
    while (a > 2880) a -= 5760;
    while (a < -2880) a += 5760;
    return a;
  endfunction

  // middle sensors on the line, neither side fully black
  function automatic logic [7:0] line_on_track();
    logic [7:0] b;
    b = 8'($urandom);
    b[4:3] = 2'b00;
    if (b[2:0] == 3'b000) b[$urandom_range(0, 2)] = 1'b1;
    if (b[7:5] == 3'b000) b[$urandom_range(5, 7)] = 1'b1;
    return b;
  endfunction

  // middle sensors off the line, no corner either
  function automatic logic [7:0] line_off_mid();
    logic [7:0] b;
    b = 8'($urandom);
    if (b[4:3] == 2'b00) b[$urandom_range(3, 4)] = 1'b1;
    if (b[3:0] == 4'h0) b[$urandom_range(0, 3)] = 1'b1;
    if (b[7:4] == 4'h0) b[$urandom_range(4, 7)] = 1'b1;
    return b;
  endfunction

  function automatic logic [7:0] line_corner(input int side);
    logic [7:0] b;
    b = 8'($urandom);
    case (side)
      SIDE_LEFT:  b[3:0] = 4'h0;
      SIDE_RIGHT: b[7:4] = 4'h0;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

  // drive forward in a few steps until strictly past lim
  task automatic ramp_distance(input logic [15:0] lim, input bit keep_off_mid);
    int span;
    int covered;
    int step;
    span    = int'(lim);
    covered = 0;
    do begin
      step = span / 3 + 1 + $urandom_range(0, span / 4);
      covered += step;
      gen_dist += step;
      push_tick(KIND_TICK, gen_yaw, gen_dist,
                keep_off_mid ? line_off_mid() : 8'($urandom));
    end while (covered <= span);
  endtask

  // swing the heading toward goal, last tick lands inside the band
  task automatic swing_to(input int goal);
    int start_y;
    int delta;
    int steps;
    int off;
    start_y = gen_yaw;
    delta   = wrap_yaw(goal - start_y);
    steps   = $urandom_range(1, 4);
    for (int i = 0; i < steps; i++) begin
      gen_yaw = wrap_yaw(start_y + delta * i / steps);
      push_tick(KIND_TICK, gen_yaw, gen_dist, 8'($urandom));
    end
    off = (cfg_band > 1) ? $urandom_range(0, int'(cfg_band) - 1) : 0;
    if ($urandom_range(0, 1)) off = -off;
    gen_yaw = wrap_yaw(goal + off);
    push_tick(KIND_TICK, gen_yaw, gen_dist, 8'($urandom));
  endtask

  task automatic push_noise(input int n);
    repeat (n) begin
      push_tick(($urandom_range(0, 4) == 0) ? KIND_RESTART : KIND_TICK,
                $urandom, $urandom, 8'($urandom));
    end
  endtask

  // one well-formed corner pass with random content, a few broken on purpose
  task automatic drive_corner();
    int side;
    int goal;
    int origin_y;
    int n;
    int step_max;
    if ($urandom_range(0, 3) == 0) gen_dist = $urandom;
    if ($urandom_range(0, 99) < 30) begin
      gen_yaw = $urandom_range(0, 5760) - 2880;
      push_tick(KIND_RESTART, gen_yaw, gen_dist, 8'($urandom));
      ramp_distance(cfg_startup, 1'b0);
      gen_dist = $urandom_range(0, 20);  // encoder zeroed after startup
    end
    n = $urandom_range(0, 4);
    repeat (n) begin
      gen_dist += $urandom_range(0, 50);
      push_tick(KIND_TICK, gen_yaw, gen_dist,
                $urandom_range(0, 1) ? line_on_track() : line_off_mid());
    end
    side = $urandom_range(SIDE_LEFT, SIDE_BOTH);
    // interrupted debounce
    if ($urandom_range(0, 4) == 0) begin
      push_tick(KIND_TICK, gen_yaw, gen_dist, line_corner(side));
      push_tick(KIND_TICK, gen_yaw, gen_dist, line_on_track());
    end
    n = (cfg_debounce == 0) ? 1 : int'(cfg_debounce);
    repeat (n) push_tick(KIND_TICK, gen_yaw, gen_dist, line_corner(side));
    origin_y = gen_yaw;
    goal = (side == SIDE_RIGHT) ? origin_y - int'(cfg_angle) : origin_y + int'(cfg_angle);
    ramp_distance(cfg_advance, 1'b0);
    swing_to(goal);
    // diagonal: either the middle sensors find the line or the limit runs out
    if ($urandom_range(0, 99) < 60) begin
      n = $urandom_range(1, 4);
      step_max = int'(cfg_limit) / (n + 1);
      repeat (n) begin
        gen_dist += $urandom_range(0, step_max);
        push_tick(KIND_TICK, gen_yaw, gen_dist, line_off_mid());
      end
      push_tick(KIND_TICK, gen_yaw, gen_dist, line_on_track());
    end else begin
      ramp_distance(cfg_limit, 1'b1);
    end
    ramp_distance(cfg_return, 1'b0);
    swing_to(origin_y);
    if ($urandom_range(0, 9) == 0) push_noise($urandom_range(1, 3));
  endtask

  // Directed opening with reset settings: wrap of distance, both sides black,
  // turn-back across the half turn, right-side corner, heading and distance extremes
  task automatic push_directed();
    push_tick(KIND_TICK,    0,     32'h0000_0000, 8'hE7);  // follow
    push_tick(KIND_RESTART, 2880,  32'h7FFF_FF00, 8'h00);  // startup
    push_tick(KIND_TICK,    2880,  32'h8000_0090, 8'hE7);  // exactly at limit, hold
    push_tick(KIND_TICK,    2880,  32'h8000_0091, 8'hE7);  // past across wrap
    push_tick(KIND_TICK,    -2880, 32'hFFFF_FF9C, 8'hFF);  // no sensor black
    repeat (3) push_tick(KIND_TICK, -2880, 32'hFFFF_FF9C, 8'h00);  // both sides
    push_tick(KIND_TICK,    -2880, 32'd200,       8'hFF);  // advance at limit
    push_tick(KIND_TICK,    -2880, 32'd201,       8'hFF);  // advance done
    push_tick(KIND_TICK,    -2880, 32'd201,       8'hFF);  // turning
    push_tick(KIND_TICK,    -760,  32'd201,       8'hFF);  // inside band
    push_tick(KIND_TICK,    -760,  32'd300,       8'hFF);  // diagonal
    push_tick(KIND_TICK,    -760,  32'd300,       8'hE7);  // line found
    push_tick(KIND_TICK,    -760,  32'd700,       8'hFF);
    push_tick(KIND_TICK,    -760,  32'd701,       8'hFF);
    push_tick(KIND_TICK,    2880,  32'd701,       8'hFF);  // same heading, wrapped
    repeat (3) push_tick(KIND_TICK, 100, 32'd0, 8'h0F);    // right side
    push_tick(KIND_TICK,    100,   32'h7FFF_FFFF, 8'hFF);
    push_tick(KIND_TICK,    -4096, 32'h7FFF_FFFF, 8'hFF);
    push_tick(KIND_TICK,    4095,  32'h7FFF_FFFF, 8'hFF);
    push_tick(KIND_TICK,    -2100, 32'h7FFF_FFFF, 8'hFF);
    push_tick(KIND_TICK,    -2100, 32'h8000_0000, 8'hFF);
    push_tick(KIND_TICK,    -2100, 32'h8000_11F8, 8'hFF);  // limit reached
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    int quota;
    push_directed();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s > 0) begin
        wait_idle();
        case (s)
          1: program_setting(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
          2: program_setting(16'd15, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
                             16'd2880, 16'd480, 16'd100);
          3: program_setting(16'd0, 16'd50, 16'd20, 16'd200, 16'd30,
                             16'd1440, 16'd16, 16'd37);
          7: program_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          default: program_setting(16'($urandom_range(0, 15)), 16'($urandom_range(0, 600)),
                                   16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)),
                                   16'($urandom_range(0, 600)), 16'($urandom_range(0, 2880)),
                                   16'($urandom_range(1, 480)), 16'($urandom_range(0, 100)));
        endcase
      end
      quota = queued + TICKS_PER_SETTING;
      while (queued < quota) drive_corner();
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[corner_turn_sequencer] OK");
    end else begin
      $display("[corner_turn_sequencer] ERROR");
    end
    $finish;
  end

endmodule
